// ===== src/pafk_pkg.sv =====
// shared types, constants and helper functions of the planar arm kinematics core
package pafk_pkg;

  localparam int PHASE_W     = 32;
  localparam int LEN_W       = 16;
  localparam int POS_W       = 32;
  localparam int XY_W        = 33;
  localparam int GAIN_W      = 32;
  localparam int PROD_W      = XY_W + GAIN_W;
  localparam int ROUND_SHIFT = 44;
  localparam int DX_W        = PROD_W - ROUND_SHIFT;
  localparam int LEN_SHIFT   = 14;
  localparam int QUEUE_DEPTH = 2;
  localparam int ATAN_IDX_W  = 5;

  localparam logic signed [GAIN_W-1:0] INV_GAIN = 32'sd652032875;

  typedef enum logic [1:0] {
    QUAD_0   = 2'd0,
    QUAD_90  = 2'd1,
    QUAD_180 = 2'd2,
    QUAD_270 = 2'd3
  } quad_e;

  typedef struct packed {
    logic [15:0] joint_angle;
    logic [15:0] link_length;
    logic        last_link;
  } in_t;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic               arm_done;
  } out_t;

  // queue entry: absolute link direction as a full-turn phase
  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [LEN_W-1:0]   link_length;
    logic               last_link;
  } link_t;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:    r = 32'h2000_0000;
      5'd1:    r = 32'h12E4_051E;
      5'd2:    r = 32'h09FB_385B;
      5'd3:    r = 32'h0511_11D4;
      5'd4:    r = 32'h028B_0D43;
      5'd5:    r = 32'h0145_D7E1;
      5'd6:    r = 32'h00A2_F61E;
      5'd7:    r = 32'h0051_7C55;
      5'd8:    r = 32'h0028_BE53;
      5'd9:    r = 32'h0014_5F2F;
      5'd10:   r = 32'h000A_2F98;
      5'd11:   r = 32'h0005_17CC;
      5'd12:   r = 32'h0002_8BE6;
      5'd13:   r = 32'h0001_45F3;
      5'd14:   r = 32'h0000_A2FA;
      5'd15:   r = 32'h0000_517D;
      5'd16:   r = 32'h0000_28BE;
      5'd17:   r = 32'h0000_145F;
      5'd18:   r = 32'h0000_0A30;
      5'd19:   r = 32'h0000_0518;
      5'd20:   r = 32'h0000_028C;
      5'd21:   r = 32'h0000_0146;
      5'd22:   r = 32'h0000_00A3;
      5'd23:   r = 32'h0000_0051;
      default: r = 32'h0000_0000;
    endcase
    return r;
  endfunction

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_W:0] v);
    logic signed [POS_W-1:0] r;
    if (v[POS_W] != v[POS_W-1]) begin
      r = v[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== src/pafk_fifo.sv =====
// short link queue between the angle front end and the rotation back end
module pafk_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  pafk_pkg::link_t  push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             not_empty_o,
  output pafk_pkg::link_t  pop_data_o
);

  localparam int DEPTH = pafk_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pafk_pkg::link_t  mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o      = (count_q == CNT_W'(DEPTH));
  assign not_empty_o = (count_q != '0);
  assign pop_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH)) else $error("queue count beyond depth");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0) else $error("queue popped while empty");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> count_q != CNT_W'(DEPTH)) else $error("queue pushed while full");

endmodule

// ===== src/pafk_front.sv =====
// input side: takes links, accumulates the joint angle and queues absolute phases
module pafk_front #(
  parameter int ANGLE_BITS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  pafk_pkg::in_t   in_data_i,
  input  logic            q_full_i,
  output logic            push_o,
  output pafk_pkg::link_t push_data_o
);

  logic [ANGLE_BITS-1:0] angle_q, angle_d;
  logic [ANGLE_BITS-1:0] theta;
  logic                  accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign push_o     = accept;

  // angle sum wraps modulo one turn
  assign theta = angle_q + ANGLE_BITS'(in_data_i.joint_angle);

  assign push_data_o.phase       = {theta, {(pafk_pkg::PHASE_W-ANGLE_BITS){1'b0}}};
  assign push_data_o.link_length = in_data_i.link_length;
  assign push_data_o.last_link   = in_data_i.last_link;

  always_comb begin
    angle_d = angle_q;
    if (accept) begin
      angle_d = in_data_i.last_link ? '0 : theta;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q <= '0;
    end else begin
      angle_q <= angle_d;
    end
  end

  a_last_clears_angle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_data_i.last_link |=> angle_q == '0) else $error("angle not cleared after arm");

  a_idle_holds_angle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(angle_q)) else $error("angle changed without transaction");

endmodule

// ===== src/pafk_back.sv =====
// execution side: cordic rotation, gain removal, position accumulation, output register
module pafk_back #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_not_empty_i,
  input  pafk_pkg::link_t q_data_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output pafk_pkg::out_t  out_data_o
);

  localparam int XY_W   = pafk_pkg::XY_W;
  localparam int PROD_W = pafk_pkg::PROD_W;
  localparam int DX_W   = pafk_pkg::DX_W;
  localparam int POS_W  = pafk_pkg::POS_W;
  localparam int N      = CORDIC_STAGES;

  logic en;

  logic signed [XY_W-1:0] x_q [N+1];
  logic signed [XY_W-1:0] y_q [N+1];
  logic signed [31:0]     z_q [N+1];
  logic [N:0]             v_q;
  logic [N:0]             last_q;

  logic signed [PROD_W-1:0] mx_q, my_q;
  logic                     mv_q, mlast_q;
  logic signed [DX_W-1:0]   dx_q, dy_q;
  logic                     rv_q, rlast_q;

  logic signed [POS_W-1:0]  pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic signed [POS_W-1:0]  end_x, end_y;
  logic                     out_valid_q;
  pafk_pkg::out_t           out_q;

  // pre-rotation of the queued link
  logic [31:0]            phase_plus;
  pafk_pkg::quad_e        quad;
  logic [31:0]            resid;
  logic signed [XY_W-1:0] mag;
  logic signed [XY_W-1:0] x0, y0;

  logic signed [PROD_W-1:0] rnd_half;
  logic signed [PROD_W-1:0] sum_x, sum_y;

  // whole back end advances unless a finished transaction is held at the output
  assign en    = !(out_valid_q && out_stall_i);
  assign pop_o = en && q_not_empty_i;

  assign phase_plus = q_data_i.phase + 32'h2000_0000;
  assign quad       = pafk_pkg::quad_e'(phase_plus[31:30]);
  assign resid      = q_data_i.phase - {phase_plus[31:30], 30'd0};
  assign mag        = $signed(XY_W'({q_data_i.link_length, {pafk_pkg::LEN_SHIFT{1'b0}}}));

  always_comb begin
    case (quad)
      pafk_pkg::QUAD_0: begin
        x0 = mag;
        y0 = '0;
      end
      pafk_pkg::QUAD_90: begin
        x0 = '0;
        y0 = mag;
      end
      pafk_pkg::QUAD_180: begin
        x0 = -mag;
        y0 = '0;
      end
      pafk_pkg::QUAD_270: begin
        x0 = '0;
        y0 = -mag;
      end
      default: begin
        x0 = '0;
        y0 = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q[0] <= x0;
      y_q[0] <= y0;
      z_q[0] <= $signed(resid);
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [XY_W-1:0] xs, ys;
    logic signed [31:0]     at;

    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;
    assign at = $signed(pafk_pkg::atan_turn(pafk_pkg::ATAN_IDX_W'(i)));

    always_ff @(posedge clk_i) begin
      if (en) begin
        if (!z_q[i][31]) begin
          x_q[i+1] <= x_q[i] - ys;
          y_q[i+1] <= y_q[i] + xs;
          z_q[i+1] <= z_q[i] - at;
        end else begin
          x_q[i+1] <= x_q[i] + ys;
          y_q[i+1] <= y_q[i] - xs;
          z_q[i+1] <= z_q[i] + at;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q  <= '0;
      mv_q <= 1'b0;
      rv_q <= 1'b0;
    end else if (en) begin
      v_q  <= {v_q[N-1:0], pop_o};
      mv_q <= v_q[N];
      rv_q <= mv_q;
    end
  end

  // gain removal, then rounding to q8.8 in the next stage
  assign rnd_half = $signed({{(PROD_W-pafk_pkg::ROUND_SHIFT){1'b0}}, 1'b1,
                             {(pafk_pkg::ROUND_SHIFT-1){1'b0}}});
  assign sum_x = mx_q + rnd_half;
  assign sum_y = my_q + rnd_half;

  always_ff @(posedge clk_i) begin
    if (en) begin
      last_q  <= {last_q[N-1:0], q_data_i.last_link};
      mx_q    <= x_q[N] * pafk_pkg::INV_GAIN;
      my_q    <= y_q[N] * pafk_pkg::INV_GAIN;
      mlast_q <= last_q[N];
      dx_q    <= sum_x[PROD_W-1:pafk_pkg::ROUND_SHIFT];
      dy_q    <= sum_y[PROD_W-1:pafk_pkg::ROUND_SHIFT];
      rlast_q <= mlast_q;
    end
  end

  // position recurrence, one link per cycle while the output is not held
  assign end_x = pafk_pkg::sat_pos((POS_W+1)'(pos_x_q) + (POS_W+1)'(dx_q));
  assign end_y = pafk_pkg::sat_pos((POS_W+1)'(pos_y_q) + (POS_W+1)'(dy_q));

  always_comb begin
    pos_x_d = pos_x_q;
    pos_y_d = pos_y_q;
    if (en && rv_q) begin
      pos_x_d = rlast_q ? '0 : end_x;
      pos_y_d = rlast_q ? '0 : end_y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_x_q <= pos_x_d;
      pos_y_q <= pos_y_d;
      if (en) begin
        out_valid_q <= rv_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && rv_q) begin
      out_q.start_x  <= pos_x_q;
      out_q.start_y  <= pos_y_q;
      out_q.end_x    <= end_x;
      out_q.end_y    <= end_y;
      out_q.arm_done <= rlast_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_last_clears_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && rv_q && rlast_q |=> pos_x_q == '0 && pos_y_q == '0)
    else $error("position not cleared after arm");

  a_hold_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(pos_x_q) && $stable(pos_y_q))
    else $error("position moved while output held");

  a_chain_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && rv_q |=> out_q.start_x == $past(pos_x_q) && out_q.start_y == $past(pos_y_q))
    else $error("start point does not follow running position");

endmodule

// ===== src/planar_arm_forward_kinematics_core.sv =====
// top level of the planar serial arm forward kinematics core
//
//   channel | valid        | stall        | payload
//   --------+--------------+--------------+--------------------------------------
//   link in | in_valid_i   | in_stall_o   | in_data_i  (joint_angle, link_length,
//           |              |              |             last_link)
//   point   | out_valid_o  | out_stall_i  | out_data_o (start_x/y, end_x/y,
//           |              |              |             arm_done)
//
// one link per cycle sustained while the output is not stalled; from accept to output valid a link
// passes the queue, the cordic pipeline, gain multiply, rounding and output registers.
// the angle sum loops through a single register at the input, the position sum at the end.
// reset clears angle sum, position and all valid bits; no clearing pass is needed.
// a stalled output freezes the whole back end; the two-entry queue absorbs up to two more
// transactions before the input stalls.
module planar_arm_forward_kinematics_core #(
  parameter int ANGLE_BITS    = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  pafk_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output pafk_pkg::out_t out_data_o
);

  logic            push;
  pafk_pkg::link_t push_data;
  logic            q_full;
  logic            pop;
  logic            q_not_empty;
  pafk_pkg::link_t pop_data;

  pafk_front #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  pafk_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .not_empty_o (q_not_empty),
    .pop_data_o  (pop_data)
  );

  pafk_back #(
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_not_empty_i (q_not_empty),
    .q_data_i      (pop_data),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_o    (out_data_o)
  );

endmodule

// ===== test/testbench.sv =====
// self-checking testbench for the planar arm forward kinematics core
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  LATENCY    = 16 + 4;
  localparam int  RAND_LINKS = 410;
  localparam int  LONG_RUN   = 50;
  localparam int  HOLD_AFTER = 800;
  localparam int  HOLD_LEN   = 300;
  localparam longint CYCLE_LIMIT = 2_000_000;

  logic           clk_i;
  logic           rst_ni      = 1'b0;
  logic           in_valid_i  = 1'b0;
  logic           in_stall_o;
  pafk_pkg::in_t  in_data_i   = '0;
  logic           out_valid_o;
  logic           out_stall_i = 1'b0;
  pafk_pkg::out_t out_data_o;

  planar_arm_forward_kinematics_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // arctangent of 2^-i, 2^32 = one turn
  longint cordic_atan [0:15] = '{
    64'h2000_0000, 64'h12E4_051E, 64'h09FB_385B, 64'h0511_11D4,
    64'h028B_0D43, 64'h0145_D7E1, 64'h00A2_F61E, 64'h0051_7C55,
    64'h0028_BE53, 64'h0014_5F2F, 64'h000A_2F98, 64'h0005_17CC,
    64'h0002_8BE6, 64'h0001_45F3, 64'h0000_A2FA, 64'h0000_517D
  };

  typedef struct {
    pafk_pkg::in_t  link;
    bit             typed;
    pafk_pkg::out_t want;
  } link_row_t;

  // arm state as the block should hold it
  logic [15:0] arm_angle = '0;
  longint      joint_x   = 0;
  longint      joint_y   = 0;

  pafk_pkg::out_t pending_points[$];
  int     mismatch_count = 0;
  int     points_seen    = 0;
  int     send_idle_pct  = 24;
  int     recv_idle_pct  = 65;
  longint cycles         = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint clamp_pos(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // rotate (length, 0) to the summed angle, then add to the current joint
  function automatic pafk_pkg::out_t next_link_points(input pafk_pkg::in_t link);
    pafk_pkg::out_t  r;
    logic [15:0]     theta;
    logic [31:0]     phase, biased, ru;
    pafk_pkg::quad_e quad;
    int signed       zi;
    longint          z, m, x, y, xs, ys, dx, dy, ex, ey;
    theta  = arm_angle + link.joint_angle;
    phase  = {theta, 16'h0000};
    biased = phase + 32'h2000_0000;
    quad   = pafk_pkg::quad_e'(biased[31:30]);
    ru     = phase - {biased[31:30], 30'b0};
    zi     = ru;
    z      = zi;
    m      = longint'(link.link_length) << pafk_pkg::LEN_SHIFT;
    case (quad)
      pafk_pkg::QUAD_0: begin
        x = m;  y = 0;
      end
      pafk_pkg::QUAD_90: begin
        x = 0;  y = m;
      end
      pafk_pkg::QUAD_180: begin
        x = -m; y = 0;
      end
      default: begin
        x = 0;  y = -m;
      end
    endcase
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - cordic_atan[i];
      end else begin
        x = x + ys; y = y - xs; z = z + cordic_atan[i];
      end
    end
    dx = (x * longint'(pafk_pkg::INV_GAIN) + (64'sd1 <<< 43)) >>> pafk_pkg::ROUND_SHIFT;
    dy = (y * longint'(pafk_pkg::INV_GAIN) + (64'sd1 <<< 43)) >>> pafk_pkg::ROUND_SHIFT;
    ex = clamp_pos(joint_x + dx);
    ey = clamp_pos(joint_y + dy);
    r.start_x  = joint_x[31:0];
    r.start_y  = joint_y[31:0];
    r.end_x    = ex[31:0];
    r.end_y    = ey[31:0];
    r.arm_done = link.last_link;
    if (link.last_link) begin
      arm_angle = '0;
      joint_x   = 0;
      joint_y   = 0;
    end else begin
      arm_angle = theta;
      joint_x   = ex;
      joint_y   = ey;
    end
    return r;
  endfunction

  // offer one link, wait for the transaction, then maybe leave a gap
  task automatic send_link(input pafk_pkg::in_t link, input bit typed = 1'b0,
                           input pafk_pkg::out_t want = '0);
    pafk_pkg::out_t predicted;
    in_valid_i <= 1'b1;
    in_data_i  <= link;
    do @(posedge clk_i); while (in_stall_o);
    predicted = next_link_points(link);
    pending_points = {pending_points, (typed ? want : predicted)};
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      in_data_i  <= pafk_pkg::in_t'(33'({$urandom(), $urandom()}));
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
  endtask

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom_range(0, 3) * 16'h4000 + 16'h2000 - $urandom_range(0, 2));
      1:       return 16'($urandom_range(0, 3) * 16'h4000);
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [15:0] pick_length();
    case ($urandom_range(0, 5))
      0:       return 16'hFFFF - 16'($urandom_range(0, 3));
      1:       return 16'($urandom_range(0, 3));
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic send_random_arms(input int count);
    int            sent, links;
    pafk_pkg::in_t link;
    sent = 0;
    while (sent < count) begin
      links = $urandom_range(1, 12);
      for (int k = 0; k < links; k++) begin
        link.joint_angle = pick_angle();
        link.link_length = pick_length();
        link.last_link   = (k == links - 1) || ($urandom_range(0, 99) < 3);
        send_link(link);
        sent++;
      end
    end
  endtask

  // a long straight arm of near-maximum links, turned once halfway
  task automatic send_long_arm(input logic [15:0] first_turn, input logic [15:0] second_turn);
    pafk_pkg::in_t link;
    for (int k = 0; k < 2 * LONG_RUN; k++) begin
      link.joint_angle = (k == 0) ? first_turn : (k == LONG_RUN) ? second_turn : 16'h0000;
      link.link_length = 16'($urandom_range(16'hF000, 16'hFFFF));
      link.last_link   = (k == 2 * LONG_RUN - 1);
      send_link(link);
    end
  endtask

  task automatic report_field(input string name, input longint want, input longint got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    end
  endtask

  // receiver: check each transaction, then decide the stall for the next cycle
  initial begin
    int             hold_left;
    bit             held;
    pafk_pkg::out_t want;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        points_seen++;
        if (pending_points.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected point, expected none got start (%0d,%0d) end (%0d,%0d)",
                   $time, out_data_o.start_x, out_data_o.start_y,
                   out_data_o.end_x, out_data_o.end_y);
        end else begin
          want = pending_points.pop_front();
          report_field("start_x", want.start_x, out_data_o.start_x);
          report_field("start_y", want.start_y, out_data_o.start_y);
          report_field("end_x", want.end_x, out_data_o.end_x);
          report_field("end_y", want.end_y, out_data_o.end_y);
          report_field("arm_done", want.arm_done, out_data_o.arm_done);
        end
        if (!held && points_seen == HOLD_AFTER) begin
          held      = 1'b1;
          hold_left = HOLD_LEN;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("FAIL planar_arm_forward_kinematics_core");
        $finish;
      end
    end
  end

  initial begin
    link_row_t directed [] = '{
      '{'{16'h0000, 16'h0000, 1'b0}, 1'b1, '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b0}},
      '{'{16'hFFFF, 16'h0000, 1'b1}, 1'b1, '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b1}},
      '{'{16'h0000, 16'hFFFF, 1'b0}, 1'b0, '0},
      '{'{16'h4000, 16'hFFFF, 1'b0}, 1'b0, '0},
      '{'{16'h4000, 16'h8000, 1'b0}, 1'b0, '0},
      '{'{16'h4000, 16'h0100, 1'b0}, 1'b0, '0},
      '{'{16'h4000, 16'h0000, 1'b0}, 1'b0, '0},
      '{'{16'h2000, 16'h0100, 1'b0}, 1'b0, '0},
      '{'{16'h1FFF, 16'h0100, 1'b0}, 1'b0, '0},
      '{'{16'hDFFF, 16'h0100, 1'b0}, 1'b0, '0},
      '{'{16'h8000, 16'h0001, 1'b0}, 1'b0, '0},
      '{'{16'hFFFF, 16'hFFFF, 1'b1}, 1'b0, '0},
      '{'{16'h5555, 16'hAAAA, 1'b0}, 1'b0, '0},
      '{'{16'hAAAA, 16'h5555, 1'b1}, 1'b0, '0},
      '{'{16'h0000, 16'h0000, 1'b1}, 1'b1, '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b1}},
      '{'{16'hE000, 16'h7FFF, 1'b0}, 1'b0, '0},
      '{'{16'h0001, 16'hFFFF, 1'b1}, 1'b0, '0}
    };
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_link(directed[i].link, directed[i].typed, directed[i].want);
    send_random_arms(RAND_LINKS);

    send_idle_pct = 65;
    recv_idle_pct = 24;
    send_random_arms(RAND_LINKS);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random_arms(RAND_LINKS);
    // along +x then -y; along -x then +y
    send_long_arm(16'h0000, 16'hC000);
    send_long_arm(16'h8000, 16'hC000);
    send_random_arms(50);

    in_valid_i <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS planar_arm_forward_kinematics_core");
    end else begin
      $display("FAIL planar_arm_forward_kinematics_core");
    end
    $finish;
  end

endmodule
